FILE: design/mfks_pkg.sv
// Package: shared types, constants and base64 helpers for the keyword scanner.
package mfks_pkg;

  localparam int KEYWORD_SLOTS_DEF     = 6;
  localparam int MAX_KEYWORD_BYTES_DEF = 6;
  localparam int OFFSET_BITS_DEF       = 16;
  localparam int KW_REGS               = 6;
  localparam int KW_BITS               = 48;
  localparam int LEN_BITS              = 18;
  localparam int CFG_IDX_BITS          = 3;
  localparam int FORMS                 = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_LENGTHS = 3'd6;

  localparam logic [1:0] FORM_PLAIN  = 2'd0;
  localparam logic [1:0] FORM_WIDE   = 2'd1;
  localparam logic [1:0] FORM_B64    = 2'd2;
  localparam logic [1:0] FORM_B64W   = 2'd3;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic                       result_kind;
    logic [2:0]                 keyword_slot;
    logic [1:0]                 match_form;
    logic [OFFSET_BITS_DEF-1:0] match_offset;
    logic                       any_match;
    logic                       last_result;
  } out_item_t;

  // Map a 6-bit value to its base64 character.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26)      c = 8'd65 + {2'b00, v};
    else if (v < 6'd52) c = 8'd71 + {2'b00, v};
    else if (v < 6'd62) c = {2'b00, v} - 8'd4;
    else if (v == 6'd62) c = 8'd43;
    else                c = 8'd47;
    return c;
  endfunction

endpackage

FILE: design/multi_form_keyword_scanner_top.sv
// Top level: keyword scanner with match front end and result back end.
//   channel | signals                     | transfer
//   input   | push, full, in_item         | push & !full
//   result  | pop, empty, out_item        | pop & !empty
//   config  | cfg_we, cfg_idx, cfg_data   | cfg_we
// One byte per cycle enters while the queue is not full; the four-deep queue
// between front and back absorbs bursts. Each queued byte drains one result
// per cycle while pop is held. A byte's results are registered into the
// queue. Reset is synchronous and clears window, queue and registers.
module multi_form_keyword_scanner_top #(
  parameter int KEYWORD_SLOTS     = mfks_pkg::KEYWORD_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mfks_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [mfks_pkg::KW_BITS-1:0]       cfg_data,
  input  logic                               push,
  output logic                               full,
  input  mfks_pkg::in_item_t                 in_item,
  output logic                               empty,
  input  logic                               pop,
  output mfks_pkg::out_item_t                out_item
);

  localparam int HITS        = KEYWORD_SLOTS * mfks_pkg::FORMS;
  localparam int OFFSET_BITS = mfks_pkg::OFFSET_BITS_DEF;

  logic [HITS-1:0]                  hit;
  logic [HITS-1:0][OFFSET_BITS-1:0] hit_off;
  logic                             eop, any, acc;

  assign acc = push & ~full;

  mfks_front #(.KEYWORD_SLOTS(KEYWORD_SLOTS)) u_front (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .in_valid(acc), .in_item, .hit, .hit_off, .eop, .any
  );

  mfks_back #(.KEYWORD_SLOTS(KEYWORD_SLOTS)) u_back (
    .clk, .rst, .push_q(acc), .hit, .hit_off, .eop, .any,
    .q_full(full), .empty, .pop, .res(out_item)
  );

endmodule

FILE: design/mfks_front.sv
// Front end: window, offset tracking and parallel match of all forms.
module mfks_front #(
  parameter int KEYWORD_SLOTS     = mfks_pkg::KEYWORD_SLOTS_DEF,
  parameter int HITS              = KEYWORD_SLOTS * mfks_pkg::FORMS
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              cfg_we,
  input  logic [mfks_pkg::CFG_IDX_BITS-1:0]                 cfg_idx,
  input  logic [mfks_pkg::KW_BITS-1:0]                      cfg_data,
  input  logic                                              in_valid,
  input  mfks_pkg::in_item_t                                in_item,
  output logic [HITS-1:0]                                   hit,
  output logic [HITS-1:0][mfks_pkg::OFFSET_BITS_DEF-1:0]    hit_off,
  output logic                                              eop,
  output logic                                              any
);

  localparam int MK          = mfks_pkg::MAX_KEYWORD_BYTES_DEF;
  localparam int OFFSET_BITS = mfks_pkg::OFFSET_BITS_DEF;
  localparam int WDEPTH      = 4 * ((2 * MK + 2) / 3) - 1;
  localparam int SPAN        = WDEPTH + 1;
  localparam int ENCW        = SPAN + 4;
  localparam int FBITS       = $clog2(WDEPTH + 1);
  localparam int EBITS       = $clog2(ENCW + 1);

  logic [mfks_pkg::KW_BITS-1:0]  kw [mfks_pkg::KW_REGS];
  logic [mfks_pkg::LEN_BITS-1:0] lens;
  logic [7:0]                    win [WDEPTH];
  logic [OFFSET_BITS-1:0]        offset;
  logic [FBITS-1:0]              fill;
  logic                          found;

  logic [7:0]  recent [SPAN];
  logic [HITS-1:0] hit_c;
  logic        prim;

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < mfks_pkg::KW_REGS; r++) kw[r] <= '0;
      lens <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == mfks_pkg::REG_LENGTHS) lens <= cfg_data[mfks_pkg::LEN_BITS-1:0];
      else if (cfg_idx < mfks_pkg::REG_LENGTHS) kw[cfg_idx] <= cfg_data;
    end
  end

  always_comb begin
    recent[0] = in_item.data_byte;
    for (int i = 1; i < SPAN; i++) recent[i] = win[i-1];
  end

  // Compare every slot and form against the window.
  always_comb begin
    logic [2:0]  len;
    logic [7:0]  pl [MK];
    logic [7:0]  wd [2*MK];
    logic [7:0]  e0 [ENCW];
    logic [7:0]  e1 [ENCW];
    logic [EBITS-1:0] el0, el1;
    logic [23:0] v;
    logic        m;
    int          n;
    int          ln [4];
    hit_c = '0;
    prim  = 1'b0;
    hit_off = '0;
    v = '0;
    for (int s = 0; s < KEYWORD_SLOTS; s++) begin
      len = lens[3*s +: 3];
      n = int'(len);
      if (n > MK) n = MK;
      for (int i = 0; i < MK; i++) begin
        pl[i] = kw[s][8*i +: 8];
        wd[2*i] = pl[i];
        wd[2*i+1] = 8'd0;
      end
      for (int i = 0; i < ENCW; i++) begin
        e0[i] = 8'd0;
        e1[i] = 8'd0;
      end
      el0 = '0;
      el1 = '0;
      for (int g = 0; g < MK; g += 3) begin
        if (g < n) begin
          v = {pl[g], (g+1 < n && g+1 < MK) ? pl[(g+1)%MK] : 8'd0,
               (g+2 < n && g+2 < MK) ? pl[(g+2)%MK] : 8'd0};
          e0[4*g/3]   = mfks_pkg::b64_char(v[23:18]);
          e0[4*g/3+1] = mfks_pkg::b64_char(v[17:12]);
          e0[4*g/3+2] = (g+1 < n) ? mfks_pkg::b64_char(v[11:6]) : 8'd61;
          e0[4*g/3+3] = (g+2 < n) ? mfks_pkg::b64_char(v[5:0]) : 8'd61;
          el0 = EBITS'(4*g/3 + 4);
        end
      end
      for (int g = 0; g < 2*MK; g += 3) begin
        if (g < 2*n) begin
          v = {wd[g], (g+1 < 2*n) ? wd[(g+1)%(2*MK)] : 8'd0,
               (g+2 < 2*n) ? wd[(g+2)%(2*MK)] : 8'd0};
          e1[4*g/3]   = mfks_pkg::b64_char(v[23:18]);
          e1[4*g/3+1] = mfks_pkg::b64_char(v[17:12]);
          e1[4*g/3+2] = (g+1 < 2*n) ? mfks_pkg::b64_char(v[11:6]) : 8'd61;
          e1[4*g/3+3] = (g+2 < 2*n) ? mfks_pkg::b64_char(v[5:0]) : 8'd61;
          el1 = EBITS'(4*g/3 + 4);
        end
      end
      ln[0] = n; ln[1] = 2*n; ln[2] = int'(el0); ln[3] = int'(el1);
      for (int f = 0; f < 4; f++) begin
        m = (n != 0) && (ln[f] <= int'(fill) + 1) && (ln[f] <= SPAN);
        for (int i = 0; i < SPAN; i++) begin
          if (i < ln[f]) begin
            case (f)
              0: if (i < MK && pl[i%MK] != recent[(ln[f]-1-i+SPAN)%SPAN]) m = 1'b0;
              1: if (wd[i%(2*MK)] != recent[(ln[f]-1-i+SPAN)%SPAN]) m = 1'b0;
              2: if (e0[i] != recent[(ln[f]-1-i+SPAN)%SPAN]) m = 1'b0;
              default: if (e1[i] != recent[(ln[f]-1-i+SPAN)%SPAN]) m = 1'b0;
            endcase
          end
        end
        hit_c[4*s+f] = m;
        if (m && f < 2) prim = 1'b1;
        hit_off[4*s+f] = (offset >= OFFSET_BITS'(ln[f]-1))
                         ? offset - OFFSET_BITS'(ln[f]-1) : '0;
      end
    end
  end

  assign hit = in_valid ? hit_c : '0;
  assign eop = in_valid & in_item.end_of_packet;
  assign any = found | prim;

  // Advance window and packet state on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WDEPTH; i++) win[i] <= '0;
      offset <= '0;
      fill   <= '0;
      found  <= 1'b0;
    end else if (in_valid) begin
      win[0] <= in_item.data_byte;
      for (int i = 1; i < WDEPTH; i++) win[i] <= win[i-1];
      if (in_item.end_of_packet) begin
        offset <= '0;
        fill   <= '0;
        found  <= 1'b0;
      end else begin
        if (fill < FBITS'(WDEPTH)) fill <= fill + 1'b1;
        if (offset != '1) offset <= offset + 1'b1;
        if (prim) found <= 1'b1;
      end
    end
  end

endmodule

FILE: design/mfks_back.sv
// Back end: queue of bytes with hits or packet end, and serialization into result items.
module mfks_back #(
  parameter int KEYWORD_SLOTS = mfks_pkg::KEYWORD_SLOTS_DEF,
  parameter int HITS          = KEYWORD_SLOTS * mfks_pkg::FORMS
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            push_q,
  input  logic [HITS-1:0]                                 hit,
  input  logic [HITS-1:0][mfks_pkg::OFFSET_BITS_DEF-1:0]  hit_off,
  input  logic                                            eop,
  input  logic                                            any,
  output logic                                            q_full,
  output logic                                            empty,
  input  logic                                            pop,
  output mfks_pkg::out_item_t                             res
);

  localparam int OFFSET_BITS = mfks_pkg::OFFSET_BITS_DEF;
  localparam int QD = 4;
  localparam int HB = $clog2(HITS);

  logic [HITS-1:0]                  qh  [QD];
  logic [HITS-1:0][OFFSET_BITS-1:0] qo  [QD];
  logic                             qe  [QD];
  logic                             qa  [QD];
  logic [1:0]                       wp, rp;
  logic [2:0]                       cnt;
  logic [HITS-1:0]                  done;   // hits of head entry already sent
  logic [HITS-1:0]                  rem;
  logic [HB-1:0]                    idx;
  logic                             has_hit, more, head_valid, take, adv;
  logic                             useful;

  assign useful = (|hit) | eop;
  assign q_full = (cnt == 3'(QD));
  assign head_valid = (cnt != '0);

  // Pick lowest pending hit of the head entry.
  always_comb begin
    rem = qh[rp] & ~done;
    idx = '0;
    has_hit = 1'b0;
    for (int i = HITS-1; i >= 0; i--) begin
      if (rem[i]) begin
        idx = HB'(i);
        has_hit = 1'b1;
      end
    end
    more = |(rem & ~(HITS'(1) << idx));
  end

  assign empty = ~head_valid;
  assign take  = pop & head_valid;
  assign adv   = take & (has_hit ? (~more & ~qe[rp]) : 1'b1);

  always_comb begin
    res = '0;
    if (has_hit) begin
      res.result_kind  = mfks_pkg::KIND_MATCH;
      res.keyword_slot = 3'(idx >> 2);
      res.match_form   = idx[1:0];
      res.match_offset = qo[rp][idx];
      res.last_result  = ~more & ~qe[rp];
    end else begin
      res.result_kind  = mfks_pkg::KIND_SUMMARY;
      res.any_match    = qa[rp];
      res.last_result  = 1'b1;
    end
  end

  // Hold queue entries and pointers.
  always_ff @(posedge clk) begin
    if (push_q && useful) begin
      qh[wp] <= hit;
      qo[wp] <= hit_off;
      qe[wp] <= eop;
      qa[wp] <= any;
    end
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; done <= '0;
    end else begin
      if (push_q && useful) wp <= wp + 1'b1;
      if (adv) begin
        rp <= rp + 1'b1;
        done <= '0;
      end else if (take && has_hit) begin
        done <= done | (HITS'(1) << idx);
      end
      cnt <= cnt + 3'(push_q && useful) - 3'(adv);
    end
  end

endmodule

FILE: design/mfks_checker.sv
// Checker: port-level properties of the scanner, bound to the top level.
module mfks_checker (
  input logic                clk,
  input logic                rst,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input mfks_pkg::out_item_t out_item
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("not empty after reset");
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.result_kind) |-> out_item.last_result)
    else $error("summary not last");
  a_match_noany: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.result_kind) |-> !out_item.any_match)
    else $error("any_match on match");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(out_item))
    else $error("result changed while stalled");

endmodule

bind multi_form_keyword_scanner_top mfks_checker u_chk (
  .clk, .rst, .push, .full, .empty, .pop, .out_item
);

FILE: test/keyword_match_checker.sv
// Checker for the keyword scanner: predicts results of each byte transfer and compares them.
module keyword_match_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mfks_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [mfks_pkg::KW_BITS-1:0]      cfg_data,
  input  logic                              push,
  input  logic                              full,
  input  mfks_pkg::in_item_t                in_item,
  input  logic                              empty,
  input  logic                              pop,
  input  mfks_pkg::out_item_t               out_item,
  output int                                fail_count,
  output int                                pending,
  output int                                bytes_seen,
  output int                                matches_seen,
  output int                                summaries_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_DEPTH = 15;
  localparam int SPAN      = WIN_DEPTH + 1;
  localparam int SLOT_MAX  = mfks_pkg::MAX_KEYWORD_BYTES_DEF;

  logic [mfks_pkg::KW_BITS-1:0]  kw_reg [mfks_pkg::KW_REGS];
  logic [mfks_pkg::LEN_BITS-1:0] kw_lens;
  logic [7:0]                    window [WIN_DEPTH];
  logic [15:0]                   pkt_offset;
  int                            fill;
  logic                          seen_text;
  mfks_pkg::out_item_t           expected_results [$];

  assign pending = expected_results.size();

  // Build the byte text of one keyword form; returns its length.
  function automatic int encode_form(input logic [mfks_pkg::KW_BITS-1:0] kw, input int len,
                                     input logic [1:0] form, output logic [7:0] txt [SPAN]);
    string       abc;
    logic [7:0]  src [2*SLOT_MAX];
    int          n;
    int          o;
    logic [23:0] v;
    abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    for (int i = 0; i < SPAN; i++) txt[i] = 8'h00;
    n = (form == mfks_pkg::FORM_WIDE || form == mfks_pkg::FORM_B64W) ? 2 * len : len;
    for (int i = 0; i < len; i++) begin
      if (n == len) begin
        src[i] = kw[8*i +: 8];
      end else begin
        src[2*i]   = kw[8*i +: 8];
        src[2*i+1] = 8'h00;
      end
    end
    if (form == mfks_pkg::FORM_PLAIN || form == mfks_pkg::FORM_WIDE) begin
      for (int i = 0; i < n; i++) txt[i] = src[i];
      return n;
    end
    o = 0;
    for (int i = 0; i < n; i += 3) begin
      v = {src[i], (i + 1 < n) ? src[i+1] : 8'h00, (i + 2 < n) ? src[i+2] : 8'h00};
      txt[o]   = abc[v[23:18]];
      txt[o+1] = abc[v[17:12]];
      txt[o+2] = (i + 1 < n) ? abc[v[11:6]] : "=";
      txt[o+3] = (i + 2 < n) ? abc[v[5:0]] : "=";
      o += 4;
    end
    return o;
  endfunction

  // Work out the results caused by one byte and advance the scan state.
  task automatic scan_byte(input mfks_pkg::in_item_t it);
    logic [7:0]          recent [SPAN];
    logic [7:0]          txt [SPAN];
    mfks_pkg::out_item_t r;
    int                  len, n, avail, first;
    logic                hit;
    first = expected_results.size();
    avail = fill + 1;
    recent[0] = it.data_byte;
    for (int i = 1; i < SPAN; i++) recent[i] = window[i-1];
    for (int s = 0; s < mfks_pkg::KW_REGS; s++) begin
      len = int'(kw_lens[3*s +: 3]);
      if (len > SLOT_MAX) len = SLOT_MAX;
      if (len == 0) continue;
      for (int f = 0; f < mfks_pkg::FORMS; f++) begin
        n = encode_form(kw_reg[s], len, f[1:0], txt);
        hit = (n <= avail) && (n <= SPAN);
        for (int i = 0; i < n && hit; i++)
          if (txt[i] != recent[n-1-i]) hit = 1'b0;
        if (hit) begin
          r = '0;
          r.result_kind  = mfks_pkg::KIND_MATCH;
          r.keyword_slot = s[2:0];
          r.match_form   = f[1:0];
          r.match_offset = (pkt_offset >= n - 1) ? pkt_offset - 16'(n - 1) : 16'd0;
          expected_results.push_back(r);
          if (f < 2) seen_text = 1'b1;
        end
      end
    end
    if (it.end_of_packet) begin
      r = '0;
      r.result_kind = mfks_pkg::KIND_SUMMARY;
      r.any_match   = seen_text;
      expected_results.push_back(r);
    end
    if (expected_results.size() > first)
      expected_results[expected_results.size()-1].last_result = 1'b1;
    // shift the window and advance the packet position
    for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = it.data_byte;
    if (it.end_of_packet) begin
      pkt_offset = '0;
      fill = 0;
      seen_text = 1'b0;
    end else begin
      if (fill < WIN_DEPTH) fill++;
      if (pkt_offset != 16'hFFFF) pkt_offset++;
    end
  endtask

  always @(posedge clk) begin
    mfks_pkg::out_item_t want;
    if (rst) begin
      for (int i = 0; i < mfks_pkg::KW_REGS; i++) kw_reg[i] = '0;
      for (int i = 0; i < WIN_DEPTH; i++) window[i] = '0;
      kw_lens = '0;
      pkt_offset = '0;
      fill = 0;
      seen_text = 1'b0;
      expected_results.delete();
      fail_count = 0;
      bytes_seen = 0;
      matches_seen = 0;
      summaries_seen = 0;
    end else begin
      // compare a result transfer against the oldest prediction
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item !== want) begin
            $display("%0t: result mismatch: expected %p, actual %p", $time, want, out_item);
            fail_count++;
          end
          if (want.result_kind == mfks_pkg::KIND_SUMMARY) summaries_seen++;
          else matches_seen++;
        end
      end
      // predict a byte transfer with the registers in force before this edge
      if (push && !full) begin
        scan_byte(in_item);
        bytes_seen++;
      end
      // track register writes
      if (cfg_we) begin
        if (cfg_idx == mfks_pkg::REG_LENGTHS) kw_lens = cfg_data[mfks_pkg::LEN_BITS-1:0];
        else if (cfg_idx < mfks_pkg::REG_LENGTHS) kw_reg[cfg_idx] = cfg_data;
      end
    end
  end

endmodule

FILE: test/testbench.sv
// Testbench top: drives bytes and register writes into the keyword scanner and gives the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 60;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [mfks_pkg::CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [mfks_pkg::KW_BITS-1:0]      cfg_data = '0;
  logic                              push = 1'b0;
  logic                              full;
  mfks_pkg::in_item_t                in_item = '0;
  logic                              empty;
  logic                              pop = 1'b0;
  mfks_pkg::out_item_t               out_item;

  int fail_count, pending, bytes_seen, matches_seen, summaries_seen;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycles = 0;
  logic [mfks_pkg::KW_BITS-1:0]  kw_now [mfks_pkg::KW_REGS];
  logic [mfks_pkg::LEN_BITS-1:0] lens_now;

  multi_form_keyword_scanner_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  keyword_match_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .fail_count(fail_count), .pending(pending), .bytes_seen(bytes_seen),
    .matches_seen(matches_seen), .summaries_seen(summaries_seen)
  );

  always #10 clk = ~clk;

  // End the run if it hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(input logic [mfks_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [mfks_pkg::KW_BITS-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Load all six keywords and the length word
  task automatic load_keywords();
    for (int i = 0; i < mfks_pkg::KW_REGS; i++)
      write_reg(i[mfks_pkg::CFG_IDX_BITS-1:0], kw_now[i]);
    write_reg(mfks_pkg::REG_LENGTHS, {30'd0, lens_now});
  endtask

  // Offer one byte and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic eop);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_item <= '{data_byte: b, end_of_packet: eop};
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Send the given form of a slot's keyword
  task automatic send_form(input int slot, input logic [1:0] form, input logic eop_after);
    logic [7:0] txt [16];
    int         len, n;
    len = int'(lens_now[3*slot +: 3]);
    if (len > mfks_pkg::MAX_KEYWORD_BYTES_DEF) len = mfks_pkg::MAX_KEYWORD_BYTES_DEF;
    n = chk.encode_form(kw_now[slot], len, form, txt);
    for (int i = 0; i < n; i++) send_byte(txt[i], eop_after && (i == n - 1));
  endtask

  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(3));
  endfunction

  // Random keywords over a small alphabet so matches are frequent
  task automatic random_keywords();
    for (int i = 0; i < mfks_pkg::KW_REGS; i++)
      for (int b = 0; b < 6; b++) kw_now[i][8*b +: 8] = ($urandom_range(9) == 0) ?
          8'($urandom) : letter();
    for (int i = 0; i < mfks_pkg::KW_REGS; i++) lens_now[3*i +: 3] = 3'($urandom_range(7));
    if (lens_now == '0) lens_now[2:0] = 3'd2;
  endtask

  // Random packets: mostly keyword forms, some noise
  task automatic random_packets(input int target);
    int start, plen, s;
    start = bytes_seen;
    while (bytes_seen - start < target) begin
      plen = $urandom_range(8);
      for (int k = 0; k < plen; k++) begin
        s = $urandom_range(mfks_pkg::KW_REGS - 1);
        if ($urandom_range(9) < 6 && lens_now[3*s +: 3] != 0)
          send_form(s, 2'($urandom_range(3)), 1'b0);
        else if ($urandom_range(1) == 0)
          send_byte(letter(), 1'b0);
        else
          send_byte(8'($urandom), 1'b0);
      end
      send_byte(($urandom_range(1) == 0) ? letter() : 8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int idle_set [4];
    int stall_set [4];
    idle_set  = '{0, 59, 0, 7};
    stall_set = '{0, 0, 59, 7};
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: duplicate slots, over-long and disabled lengths, extreme bytes
    kw_now[0] = 48'h0000_0074_6163;      // "cat"
    kw_now[1] = 48'h0000_0074_6163;
    kw_now[2] = 48'h7465_7263_6573;      // "secret"
    kw_now[3] = 48'h0000_0000_0061;
    kw_now[4] = '1;
    kw_now[5] = '0;
    lens_now  = {3'd1, 3'd6, 3'd0, 3'd7, 3'd3, 3'd3};
    load_keywords();
    send_form(0, mfks_pkg::FORM_PLAIN, 1'b1);
    send_byte(8'h63, 1'b0);
    send_byte(8'h61, 1'b1);
    send_byte(8'h74, 1'b1);
    send_form(4, mfks_pkg::FORM_PLAIN, 1'b1);
    send_byte(8'h00, 1'b1);
    send_form(0, mfks_pkg::FORM_B64, 1'b1);
    send_form(0, mfks_pkg::FORM_WIDE, 1'b0);
    send_form(5, mfks_pkg::FORM_B64W, 1'b1);
    drain();

    // Random phases with different idling and keyword sets
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      random_keywords();
      if (p == 3) begin
        lens_now = '1;
        kw_now[5] = '0;
      end
      load_keywords();
      if (p == 0) hold_left = 300;
      random_packets(30);
      drain();
    end

    $display("scanned %0d bytes: %0d keyword matches and %0d packet summaries checked",
             bytes_seen, matches_seen, summaries_seen);
    $display("covered duplicate, disabled and over-long slots, idle/stall mixes, a full queue");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
